// File: rtl/core/ppi_pkg.sv
// Shared types and constants for the point-in-polygon block.
package ppi_pkg;

  // Fixed field widths of the stream and register interfaces
  localparam int IDX_W       = 6;
  localparam int FIELD_W     = 32;
  localparam int CNT_W       = 7;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // tdata bit positions of the input transaction
  localparam int IDX_LSB = 0;
  localparam int X_LSB   = IDX_LSB + IDX_W;
  localparam int Y_LSB   = X_LSB + FIELD_W;

  // Operation codes carried in tuser
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_TEST  = 1'b1;

  // Register index (word address bit)
  localparam logic REG_CORNER_COUNT = 1'b0;

  // Handshake between the edge walker and the product comparator
  typedef struct packed {
    logic start;
    logic neg_p;
    logic neg_q;
  } ppi_mreq_t;

  typedef struct packed {
    logic done;
    logic less;
  } ppi_mrsp_t;

endpackage

// File: rtl/core/ppi_mulcmp.sv
// Multi-cycle exact comparator of two signed products given as magnitudes and signs.
module ppi_mulcmp
  import ppi_pkg::*;
#(
  parameter int DW = 33
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ppi_mreq_t       req,
  input  logic [DW-1:0]   ma,
  input  logic [DW-1:0]   mb,
  input  logic [DW-1:0]   mc,
  input  logic [DW-1:0]   md,
  output ppi_mrsp_t       rsp
);

  localparam int H  = (DW + 1) / 2;
  localparam int PW = 2 * DW;

  typedef enum logic [1:0] {
    M_IDLE,
    M_MUL,
    M_TAIL,
    M_CMP
  } mstate_t;

  mstate_t         state_r;
  logic [1:0]      k_r;
  logic [1:0]      ppk_r;
  logic            pp_vld_r;
  logic            done_r;
  logic            less_r;
  logic            neg_p_r;
  logic            neg_q_r;
  logic [DW-1:0]   ma_r, mb_r, mc_r, md_r;
  logic [2*H-1:0]  pp1_r, pp2_r;
  logic [PW-1:0]   acc1_r, acc2_r;

  logic [H-1:0]    op_a, op_b, op_c, op_d;
  logic [2*H-1:0]  prod1, prod2;
  logic [PW-1:0]   add1, add2;
  logic            less_now;

  // halves: k[1] picks the half of the left factor, k[0] of the right one
  always_comb begin
    op_a  = k_r[1] ? H'(ma_r >> H) : H'(ma_r);
    op_b  = k_r[0] ? H'(mb_r >> H) : H'(mb_r);
    op_c  = k_r[1] ? H'(mc_r >> H) : H'(mc_r);
    op_d  = k_r[0] ? H'(md_r >> H) : H'(md_r);
    prod1 = op_a * op_b;
    prod2 = op_c * op_d;
  end

  always_comb begin
    case (ppk_r)
      2'b00: begin
        add1 = PW'(pp1_r);
        add2 = PW'(pp2_r);
      end
      2'b11: begin
        add1 = PW'(pp1_r) << (2 * H);
        add2 = PW'(pp2_r) << (2 * H);
      end
      default: begin
        add1 = PW'(pp1_r) << H;
        add2 = PW'(pp2_r) << H;
      end
    endcase
  end

  // sign-magnitude compare of P and Q
  always_comb begin
    case ({neg_p_r, neg_q_r})
      2'b10:   less_now = 1'b1;
      2'b01:   less_now = 1'b0;
      2'b11:   less_now = acc1_r > acc2_r;
      default: less_now = acc1_r < acc2_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= M_IDLE;
      k_r      <= 2'd0;
      ppk_r    <= 2'd0;
      pp_vld_r <= 1'b0;
      done_r   <= 1'b0;
      less_r   <= 1'b0;
    end else begin
      unique case (state_r)
        M_IDLE: begin
          done_r <= 1'b0;
          if (req.start) begin
            k_r      <= 2'd0;
            pp_vld_r <= 1'b0;
            state_r  <= M_MUL;
          end
        end
        M_MUL: begin
          ppk_r    <= k_r;
          pp_vld_r <= 1'b1;
          k_r      <= k_r + 2'd1;
          if (k_r == 2'd3) begin
            state_r <= M_TAIL;
          end
        end
        M_TAIL: begin
          pp_vld_r <= 1'b0;
          state_r  <= M_CMP;
        end
        M_CMP: begin
          done_r  <= 1'b1;
          less_r  <= less_now;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  // operands, partial products and accumulators
  always_ff @(posedge clk) begin
    if (state_r == M_IDLE && req.start) begin
      ma_r    <= ma;
      mb_r    <= mb;
      mc_r    <= mc;
      md_r    <= md;
      neg_p_r <= req.neg_p;
      neg_q_r <= req.neg_q;
      acc1_r  <= '0;
      acc2_r  <= '0;
    end else if (pp_vld_r) begin
      acc1_r <= acc1_r + add1;
      acc2_r <= acc2_r + add2;
    end
    if (state_r == M_MUL) begin
      pp1_r <= prod1;
      pp2_r <= prod2;
    end
  end

  assign rsp.done = done_r;
  assign rsp.less = less_r;

endmodule

// File: rtl/core/polygon_point_inclusion.sv
// Top level of the even-odd point-in-polygon tester with its vertex memory.
//
// Vertices are stored one per input transaction (tuser = 0) into a single-port
// synchronous memory of MAX_CORNERS entries holding {y, x}; a store returns
// nothing. A test transaction (tuser = 1) walks the closed edge list by
// reading one vertex per cycle while no spanning edge holds the walk, the
// previous vertex being held in registers, and returns one result
// transaction. A spanning edge, one that spans the point's y, is handed to a
// shared multi-cycle product comparator (four half-width partial products per
// product, then one compare), and the walk waits for its answer. With fewer
// than three corners a test answers outside. The memory's single read port
// and the comparator set the pace of a test. One transaction is worked on at
// a time; a finished result sits in the output register so the next
// transaction is taken while it waits. corner_count must be written through
// the APB port at address 0 only while the block is idle; the block itself
// does not enforce this. Vertices must be written before a test reads them.
module polygon_point_inclusion
  import ppi_pkg::*;
#(
  parameter int MAX_CORNERS = 64,
  parameter int COORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // vertex_index[5:0], coord_x[37:6], coord_y[69:38]
  input  logic                   in_tuser,   // op
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // inside_res[0]
  // APB register port
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;                       // difference width
  localparam int AW   = $clog2(MAX_CORNERS);
  localparam int NW   = $clog2(MAX_CORNERS + 1);
  localparam int CNTW = (NW > CNT_W) ? NW : CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOADJ,
    S_EDGE,
    S_WAIT,
    S_DONE
  } state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      corner_count_r;
  logic [AW-1:0]         i_r;
  logic [AW-1:0]         last_r;
  logic                  odd_r;
  logic                  out_tvalid_r;
  logic                  inside_r;
  logic signed [CW-1:0]  px_r, py_r;
  logic signed [CW-1:0]  xj_r, yj_r;

  // vertex memory, {y, x}
  logic [2*CW-1:0]       mem [MAX_CORNERS];
  logic [2*CW-1:0]       rd_q;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;

  // input field unpacking
  logic [IDX_W-1:0]      in_idx;
  logic signed [CW-1:0]  in_x, in_y;
  logic                  in_acc;
  logic                  idx_ok;

  logic [CNTW-1:0]       cnt_ext, n_eff;
  logic                  too_few;
  logic [AW-1:0]         last_nxt;

  logic signed [CW-1:0]  xi, yi;
  logic                  straddle;
  logic                  at_last;
  logic                  advance;
  logic [DW-1:0]         ma, mb, mc, md;
  ppi_mreq_t             mreq;
  ppi_mrsp_t             mrsp;

  assign in_idx = in_tdata[IDX_LSB +: IDX_W];
  assign in_x   = CW'($signed(in_tdata[X_LSB +: FIELD_W]));
  assign in_y   = CW'($signed(in_tdata[Y_LSB +: FIELD_W]));
  assign in_acc = in_tvalid && in_tready;
  assign idx_ok = 32'(in_idx) < 32'(MAX_CORNERS);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_TDATA_W'(inside_r);

  // corners in use, saturated to the memory depth
  assign cnt_ext  = CNTW'(corner_count_r);
  assign n_eff    = (cnt_ext > CNTW'(MAX_CORNERS)) ? CNTW'(MAX_CORNERS) : cnt_ext;
  assign too_few  = n_eff < CNTW'(3);
  assign last_nxt = AW'(n_eff - CNTW'(1));

  // edge i runs from vertex i (memory) to vertex j (registers)
  assign xi = rd_q[CW-1:0];
  assign yi = rd_q[2*CW-1:CW];

  assign straddle = ((yi < py_r) && (yj_r >= py_r)) || ((yj_r < py_r) && (yi >= py_r));

  // magnitudes after flipping the edge so that d > 0; a is then >= 0
  always_comb begin
    ma = (yj_r < yi) ? DW'(DW'(yi) - DW'(py_r)) : DW'(DW'(py_r) - DW'(yi));
    mb = (xj_r < xi) ? DW'(DW'(xi) - DW'(xj_r)) : DW'(DW'(xj_r) - DW'(xi));
    mc = (px_r < xi) ? DW'(DW'(xi) - DW'(px_r)) : DW'(DW'(px_r) - DW'(xi));
    md = (yj_r < yi) ? DW'(DW'(yi) - DW'(yj_r)) : DW'(DW'(yj_r) - DW'(yi));
  end

  assign mreq.start = (state_r == S_EDGE) && straddle;
  assign mreq.neg_p = (xj_r < xi) && (py_r != yi);   // a*b < 0
  assign mreq.neg_q = (px_r < xi);                    // c*d < 0

  assign at_last = (i_r == last_r);
  assign advance = ((state_r == S_EDGE) && !straddle) || ((state_r == S_WAIT) && mrsp.done);

  // read port requests
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = i_r + AW'(1);
    unique case (state_r)
      S_IDLE: begin
        rd_en   = in_acc && (in_tuser == OP_TEST) && !too_few;
        rd_addr = last_nxt;
      end
      S_LOADJ: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_EDGE, S_WAIT: begin
        rd_en = advance && !at_last;
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc && in_tuser == OP_STORE && idx_ok) begin
      mem[AW'(in_idx)] <= {in_y, in_x};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // walker sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      i_r          <= '0;
      last_r       <= '0;
      odd_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
      inside_r     <= 1'b0;
    end else begin
      // the done state either reloads the result register or leaves it held
      if (out_tvalid_r && out_tready && state_r != S_DONE) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_tuser == OP_TEST) begin
            odd_r  <= 1'b0;
            last_r <= last_nxt;
            state_r <= too_few ? S_DONE : S_LOADJ;
          end
        end
        S_LOADJ: begin
          i_r     <= '0;
          state_r <= S_EDGE;
        end
        S_EDGE: begin
          if (straddle) begin
            state_r <= S_WAIT;
          end else if (at_last) begin
            state_r <= S_DONE;
          end else begin
            i_r <= i_r + AW'(1);
          end
        end
        S_WAIT: begin
          if (mrsp.done) begin
            odd_r <= odd_r ^ mrsp.less;
            if (at_last) begin
              state_r <= S_DONE;
            end else begin
              i_r     <= i_r + AW'(1);
              state_r <= S_EDGE;
            end
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            inside_r     <= odd_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // point and previous-vertex registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc) begin
      px_r <= in_x;
      py_r <= in_y;
    end
    if (state_r == S_LOADJ || state_r == S_EDGE) begin
      xj_r <= xi;
      yj_r <= yi;
    end
  end

  ppi_mulcmp #(
    .DW (DW)
  ) u_mulcmp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .ma    (ma),
    .mb    (mb),
    .mc    (mc),
    .md    (md),
    .rsp   (mrsp)
  );

  // register port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_count_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_CORNER_COUNT) begin
      corner_count_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_CORNER_COUNT) ? CFG_DATA_W'(corner_count_r) : '0;

  // comparator answers only while the walker waits for it
  a_rsp_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> state_r == S_WAIT)
    else $error("comparator result outside wait state");

  // a new result is only loaded from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside done state");

  // a store transaction leaves the walker idle
  a_store_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == OP_STORE) |=> state_r == S_IDLE)
    else $error("store started a walk");

  // the edge index never passes the last corner
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDGE || state_r == S_WAIT) |-> i_r <= last_r)
    else $error("edge index past last corner");

endmodule
